// File: hdl/dllm_pkg.sv
package dllm_pkg;

  // Command codes carried on the input channel.
  typedef enum logic [3:0] {
    CMD_INIT         = 4'd0,
    CMD_ADD_FIRST    = 4'd1,
    CMD_ADD_LAST     = 4'd2,
    CMD_REMOVE_FIRST = 4'd3,
    CMD_INSERT_AFTER = 4'd4,
    CMD_REMOVE       = 4'd5,
    CMD_REMOVE_ALL   = 4'd6,
    CMD_NEXT         = 4'd7,
    CMD_PREV         = 4'd8
  } cmd_t;

  // Microprogram addresses.
  typedef logic [4:0] upc_t;

  localparam upc_t UPC_DONE  = 5'd0;
  localparam upc_t UPC_INIT  = 5'd1;
  localparam upc_t UPC_ADDF0 = 5'd2;
  localparam upc_t UPC_ADDF1 = 5'd3;
  localparam upc_t UPC_ADDF2 = 5'd4;
  localparam upc_t UPC_ADDL0 = 5'd5;
  localparam upc_t UPC_ADDL1 = 5'd6;
  localparam upc_t UPC_RMF0  = 5'd7;
  localparam upc_t UPC_RMF1  = 5'd8;
  localparam upc_t UPC_INS0  = 5'd9;
  localparam upc_t UPC_INS1  = 5'd10;
  localparam upc_t UPC_INS2  = 5'd11;
  localparam upc_t UPC_RM0   = 5'd12;
  localparam upc_t UPC_RM1   = 5'd13;
  localparam upc_t UPC_CLR0  = 5'd14;
  localparam upc_t UPC_CLR1  = 5'd15;
  localparam upc_t UPC_CLR2  = 5'd16;
  localparam upc_t UPC_NXT0  = 5'd17;
  localparam upc_t UPC_NXT1  = 5'd18;
  localparam upc_t UPC_PRV0  = 5'd19;
  localparam upc_t UPC_PRV1  = 5'd20;
  localparam upc_t UPC_LAST  = 5'd20;

  // Sources for link memory addresses, write data and working registers.
  typedef enum logic [2:0] {
    AS_NODE   = 3'd0,
    AS_ANCHOR = 3'd1,
    AS_HEAD   = 3'd2,
    AS_FIRST  = 3'd3,
    AS_LAST   = 3'd4,
    AS_RDN    = 3'd5,
    AS_RDP    = 3'd6,
    AS_TMP    = 3'd7
  } src_sel_t;

  typedef enum logic [1:0] {
    K_HOLD = 2'd0,
    K_LOAD = 2'd1,
    K_DEC  = 2'd2
  } kop_t;

  typedef enum logic [1:0] {
    CNT_HOLD  = 2'd0,
    CNT_UP    = 2'd1,
    CNT_DOWN  = 2'd2,
    CNT_CLEAR = 2'd3
  } cnt_op_t;

  typedef enum logic [2:0] {
    JC_NEXT       = 3'd0,
    JC_ALWAYS     = 3'd1,
    JC_CNT_ZERO   = 3'd2,
    JC_ANCHOR_BAD = 3'd3,
    JC_K_MORE     = 3'd4
  } jcond_t;

  // One control word of the microprogram.
  typedef struct packed {
    src_sel_t rn_sel;
    src_sel_t rp_sel;
    logic     wn_en;
    src_sel_t wn_addr;
    src_sel_t wn_data;
    logic     wp_en;
    src_sel_t wp_addr;
    src_sel_t wp_data;
    logic     tmp_ld;
    src_sel_t tmp_src;
    kop_t     k_op;
    cnt_op_t  cnt_op;
    logic     res_ld;
    src_sel_t res_src;
    logic     res_chk;
    logic     fin;
    jcond_t   jc;
    upc_t     jt;
  } ucw_t;

  // Status from the datapath used by conditional jumps and the result stall.
  typedef struct packed {
    logic cnt_zero;
    logic anchor_bad;
    logic k_one;
    logic out_busy;
  } cond_t;

  // Microprogram store.
  function automatic ucw_t ucode(upc_t a);
    ucw_t w;
    w = '0;
    case (a)
      UPC_DONE: begin
        w.fin = 1'b1;
      end
      UPC_INIT: begin
        w.wn_en = 1'b1; w.wn_addr = AS_NODE; w.wn_data = AS_NODE;
        w.wp_en = 1'b1; w.wp_addr = AS_NODE; w.wp_data = AS_NODE;
        w.jc = JC_ALWAYS; w.jt = UPC_DONE;
      end
      UPC_ADDF0: begin
        w.rp_sel = AS_FIRST;
        w.wn_en = 1'b1; w.wn_addr = AS_NODE; w.wn_data = AS_FIRST;
      end
      UPC_ADDF1: begin
        w.wp_en = 1'b1; w.wp_addr = AS_NODE; w.wp_data = AS_RDP;
      end
      UPC_ADDF2: begin
        w.wp_en = 1'b1; w.wp_addr = AS_FIRST; w.wp_data = AS_NODE;
        w.wn_en = 1'b1; w.wn_addr = AS_HEAD; w.wn_data = AS_NODE;
        w.cnt_op = CNT_UP;
        w.jc = JC_ALWAYS; w.jt = UPC_DONE;
      end
      UPC_ADDL0: begin
        w.wn_en = 1'b1; w.wn_addr = AS_NODE; w.wn_data = AS_HEAD;
        w.wp_en = 1'b1; w.wp_addr = AS_NODE; w.wp_data = AS_LAST;
      end
      UPC_ADDL1: begin
        w.wn_en = 1'b1; w.wn_addr = AS_LAST; w.wn_data = AS_NODE;
        w.wp_en = 1'b1; w.wp_addr = AS_HEAD; w.wp_data = AS_NODE;
        w.cnt_op = CNT_UP;
        w.jc = JC_ALWAYS; w.jt = UPC_DONE;
      end
      UPC_RMF0: begin
        w.rn_sel = AS_FIRST;
        w.jc = JC_CNT_ZERO; w.jt = UPC_DONE;
      end
      UPC_RMF1: begin
        w.wp_en = 1'b1; w.wp_addr = AS_RDN; w.wp_data = AS_HEAD;
        w.wn_en = 1'b1; w.wn_addr = AS_HEAD; w.wn_data = AS_RDN;
        w.res_ld = 1'b1; w.res_src = AS_FIRST;
        w.cnt_op = CNT_DOWN;
        w.jc = JC_ALWAYS; w.jt = UPC_DONE;
      end
      UPC_INS0: begin
        w.rn_sel = AS_ANCHOR;
        w.jc = JC_ANCHOR_BAD; w.jt = UPC_DONE;
      end
      UPC_INS1: begin
        w.wn_en = 1'b1; w.wn_addr = AS_NODE; w.wn_data = AS_RDN;
        w.wp_en = 1'b1; w.wp_addr = AS_NODE; w.wp_data = AS_ANCHOR;
        w.tmp_ld = 1'b1; w.tmp_src = AS_RDN;
      end
      UPC_INS2: begin
        w.wn_en = 1'b1; w.wn_addr = AS_ANCHOR; w.wn_data = AS_NODE;
        w.wp_en = 1'b1; w.wp_addr = AS_TMP; w.wp_data = AS_NODE;
        w.cnt_op = CNT_UP;
        w.jc = JC_ALWAYS; w.jt = UPC_DONE;
      end
      UPC_RM0: begin
        w.rn_sel = AS_NODE;
        w.rp_sel = AS_NODE;
      end
      UPC_RM1: begin
        w.wn_en = 1'b1; w.wn_addr = AS_RDP; w.wn_data = AS_RDN;
        w.wp_en = 1'b1; w.wp_addr = AS_RDN; w.wp_data = AS_RDP;
        w.cnt_op = CNT_DOWN;
        w.jc = JC_ALWAYS; w.jt = UPC_DONE;
      end
      UPC_CLR0: begin
        w.rn_sel = AS_FIRST;
        w.tmp_ld = 1'b1; w.tmp_src = AS_FIRST;
        w.k_op = K_LOAD;
        w.jc = JC_CNT_ZERO; w.jt = UPC_CLR2;
      end
      UPC_CLR1: begin
        w.wn_en = 1'b1; w.wn_addr = AS_TMP; w.wn_data = AS_TMP;
        w.wp_en = 1'b1; w.wp_addr = AS_TMP; w.wp_data = AS_TMP;
        w.tmp_ld = 1'b1; w.tmp_src = AS_RDN;
        w.rn_sel = AS_RDN;
        w.k_op = K_DEC;
        w.jc = JC_K_MORE; w.jt = UPC_CLR1;
      end
      UPC_CLR2: begin
        w.wn_en = 1'b1; w.wn_addr = AS_HEAD; w.wn_data = AS_HEAD;
        w.wp_en = 1'b1; w.wp_addr = AS_HEAD; w.wp_data = AS_HEAD;
        w.cnt_op = CNT_CLEAR;
        w.jc = JC_ALWAYS; w.jt = UPC_DONE;
      end
      UPC_NXT0: begin
        w.rn_sel = AS_NODE;
      end
      UPC_NXT1: begin
        w.res_ld = 1'b1; w.res_src = AS_RDN; w.res_chk = 1'b1;
        w.jc = JC_ALWAYS; w.jt = UPC_DONE;
      end
      UPC_PRV0: begin
        w.rp_sel = AS_NODE;
      end
      UPC_PRV1: begin
        w.res_ld = 1'b1; w.res_src = AS_RDP; w.res_chk = 1'b1;
        w.jc = JC_ALWAYS; w.jt = UPC_DONE;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Entry point of the microprogram for a command.
  function automatic upc_t entry_point(logic [3:0] cmd, logic node_ok);
    upc_t e;
    e = UPC_DONE;
    case (cmd)
      CMD_INIT:         e = node_ok ? UPC_INIT  : UPC_DONE;
      CMD_ADD_FIRST:    e = node_ok ? UPC_ADDF0 : UPC_DONE;
      CMD_ADD_LAST:     e = node_ok ? UPC_ADDL0 : UPC_DONE;
      CMD_REMOVE_FIRST: e = UPC_RMF0;
      CMD_INSERT_AFTER: e = node_ok ? UPC_INS0  : UPC_DONE;
      CMD_REMOVE:       e = node_ok ? UPC_RM0   : UPC_DONE;
      CMD_REMOVE_ALL:   e = UPC_CLR0;
      CMD_NEXT:         e = node_ok ? UPC_NXT0  : UPC_DONE;
      CMD_PREV:         e = node_ok ? UPC_PRV0  : UPC_DONE;
      default:          e = UPC_DONE;
    endcase
    return e;
  endfunction

endpackage

// File: hdl/dllm_ram.sv
module dllm_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/dllm_seq.sv
module dllm_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [3:0]      cmd,
  input  logic            node_ok,
  input  dllm_pkg::cond_t cond,
  output logic            slot_free,
  output dllm_pkg::ucw_t  ucw
);
  import dllm_pkg::*;

  logic busy_r, busy_nxt;
  upc_t upc_r, upc_nxt;
  ucw_t raw;
  logic go;
  logic taken;

  assign raw = ucode(upc_r);

  // The final step of an item waits while the result register is still full.
  assign go        = busy_r && !(raw.fin && cond.out_busy);
  assign slot_free = !busy_r || (raw.fin && !cond.out_busy);

  // Jump condition decode.
  always_comb begin
    case (raw.jc)
      JC_NEXT:       taken = 1'b0;
      JC_ALWAYS:     taken = 1'b1;
      JC_CNT_ZERO:   taken = cond.cnt_zero;
      JC_ANCHOR_BAD: taken = cond.anchor_bad;
      JC_K_MORE:     taken = !cond.k_one;
      default:       taken = 1'b0;
    endcase
  end

  // Step counter and busy flag.
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (accept) begin
      busy_nxt = 1'b1;
      upc_nxt  = entry_point(cmd, node_ok);
    end else if (go) begin
      if (raw.fin) begin
        busy_nxt = 1'b0;
      end else if (taken) begin
        upc_nxt = raw.jt;
      end else begin
        upc_nxt = upc_r + upc_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= UPC_DONE;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  // Control word with all side effects masked when no step executes.
  always_comb begin
    ucw = raw;
    if (!go) begin
      ucw.wn_en  = 1'b0;
      ucw.wp_en  = 1'b0;
      ucw.tmp_ld = 1'b0;
      ucw.k_op   = K_HOLD;
      ucw.cnt_op = CNT_HOLD;
      ucw.res_ld = 1'b0;
      ucw.fin    = 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_upc_range : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (upc_r <= UPC_LAST))
    else $error("step counter outside the microprogram");

  a_fin_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && raw.fin && cond.out_busy) |=> (busy_r && upc_r == UPC_DONE))
    else $error("final step left while the result register was full");
`endif

endmodule

// File: hdl/doubly_linked_list_manager.sv
// Ordered doubly linked list over POOL_NODES node handles plus a head sentinel.
// Input channel (in_*): one command item per handshake; in_tuser carries the
// command code, in_tdata the node handle and the anchor. Output channel
// (out_*): exactly one result item per command, with the returned node, its
// valid flag, the list count and the first and last nodes after the command.
// Each command runs as a short microprogram over two link memories (next and
// previous) with one write and one registered read port each; the memory ports
// set the step count. Remove first on an empty list and insert after an anchor
// past the sentinel end early, remove all walks the whole list, and ignored
// commands go straight to the final step. The result is registered: it appears
// the cycle after the final step and holds while out_tready is low; the next
// command is already accepted and runs up to its final step meanwhile.
// After reset a clearing pass self-links every memory entry, the sentinel
// included; in_tready stays low during it.
module doubly_linked_list_manager #(
  parameter int POOL_NODES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // node [NODE_W-1:0], anchor [NODE_W+LINK_W-1:NODE_W], zero padded
  input  logic [((($clog2(POOL_NODES) + $clog2(POOL_NODES + 1)) + 7) / 8) * 8 - 1:0] in_tdata,
  // cmd [3:0]
  input  logic [3:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // result_node, list_count, first_node, last_node (LINK_W bits each), zero padded
  output logic [((4 * $clog2(POOL_NODES + 1) + 7) / 8) * 8 - 1:0] out_tdata,
  // result_valid [0]
  output logic [0:0] out_tuser
);
  import dllm_pkg::*;

  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int LINK_W = $clog2(POOL_NODES + 1);
  localparam int OUT_TDATA_W = ((4 * LINK_W + 7) / 8) * 8;
  localparam logic [LINK_W-1:0] HEAD_IDX = LINK_W'(POOL_NODES);

  logic [NODE_W-1:0] in_node;
  logic [LINK_W-1:0] in_anchor;
  logic              in_node_ok;
  logic              accept;
  logic              slot_free;

  logic [NODE_W-1:0] node_r;
  logic [LINK_W-1:0] anchor_r;
  logic [LINK_W-1:0] res_r, res_nxt;
  logic [LINK_W-1:0] tmp_r;
  logic [LINK_W-1:0] k_r;
  logic [LINK_W-1:0] count_r, count_nxt;
  logic [LINK_W-1:0] head_next_r, head_prev_r;
  logic              clr_active_r;
  logic [LINK_W-1:0] clr_idx_r;

  logic              out_valid_r;
  logic [LINK_W-1:0] out_res_r, out_cnt_r, out_first_r, out_last_r;
  logic              out_rv_r;

  logic [LINK_W-1:0] rd_next, rd_prev;
  logic [LINK_W-1:0] src_v [8];
  logic              n_we, p_we;
  logic [LINK_W-1:0] n_waddr, n_wdata, p_waddr, p_wdata;

  cond_t cond;
  ucw_t  ucw;

  // Input unpacking and handshake.
  assign in_node    = in_tdata[NODE_W-1:0];
  assign in_anchor  = in_tdata[NODE_W+LINK_W-1:NODE_W];
  assign in_node_ok = LINK_W'(in_node) < HEAD_IDX;
  assign in_tready  = !clr_active_r && slot_free;
  assign accept     = in_tvalid && in_tready;

  // Status for the sequencer.
  assign cond.cnt_zero   = (count_r == '0);
  assign cond.anchor_bad = (anchor_r > HEAD_IDX);
  assign cond.k_one      = (k_r == LINK_W'(1));
  assign cond.out_busy   = out_valid_r && !out_tready;

  dllm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_tuser),
    .node_ok   (in_node_ok),
    .cond      (cond),
    .slot_free (slot_free),
    .ucw       (ucw)
  );

  // Operand sources selected by the control word.
  always_comb begin
    src_v[AS_NODE]   = LINK_W'(node_r);
    src_v[AS_ANCHOR] = anchor_r;
    src_v[AS_HEAD]   = HEAD_IDX;
    src_v[AS_FIRST]  = head_next_r;
    src_v[AS_LAST]   = head_prev_r;
    src_v[AS_RDN]    = rd_next;
    src_v[AS_RDP]    = rd_prev;
    src_v[AS_TMP]    = tmp_r;
  end

  // Link memory write ports; the clearing pass owns them after reset.
  assign n_we    = clr_active_r || ucw.wn_en;
  assign n_waddr = clr_active_r ? clr_idx_r : src_v[ucw.wn_addr];
  assign n_wdata = clr_active_r ? clr_idx_r : src_v[ucw.wn_data];
  assign p_we    = clr_active_r || ucw.wp_en;
  assign p_waddr = clr_active_r ? clr_idx_r : src_v[ucw.wp_addr];
  assign p_wdata = clr_active_r ? clr_idx_r : src_v[ucw.wp_data];

  dllm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES + 1)) u_next_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (src_v[ucw.rn_sel]),
    .rdata (rd_next)
  );

  dllm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES + 1)) u_prev_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (src_v[ucw.rp_sel]),
    .rdata (rd_prev)
  );

  // Returned node; a neighbor query that finds the node itself is invalid.
  always_comb begin
    res_nxt = src_v[ucw.res_src];
    if (ucw.res_chk && res_nxt == LINK_W'(node_r)) begin
      res_nxt = HEAD_IDX;
    end
  end

  // Saturating list count.
  always_comb begin
    count_nxt = count_r;
    case (ucw.cnt_op)
      CNT_HOLD:  count_nxt = count_r;
      CNT_UP:    count_nxt = (count_r != HEAD_IDX) ? count_r + LINK_W'(1) : count_r;
      CNT_DOWN:  count_nxt = (count_r != '0) ? count_r - LINK_W'(1) : count_r;
      CNT_CLEAR: count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
  end

  // Control state: clearing pass, count, sentinel shadows and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      count_r      <= '0;
      head_next_r  <= HEAD_IDX;
      head_prev_r  <= HEAD_IDX;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + LINK_W'(1);
        if (clr_idx_r == HEAD_IDX) begin
          clr_active_r <= 1'b0;
        end
      end
      count_r <= count_nxt;
      if (ucw.wn_en && n_waddr == HEAD_IDX) begin
        head_next_r <= n_wdata;
      end
      if (ucw.wp_en && p_waddr == HEAD_IDX) begin
        head_prev_r <= p_wdata;
      end
      if (ucw.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item operands and working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      node_r   <= in_node;
      anchor_r <= in_anchor;
      res_r    <= HEAD_IDX;
    end else if (ucw.res_ld) begin
      res_r <= res_nxt;
    end
    if (ucw.tmp_ld) begin
      tmp_r <= src_v[ucw.tmp_src];
    end
    case (ucw.k_op)
      K_HOLD:  k_r <= k_r;
      K_LOAD:  k_r <= count_r;
      K_DEC:   k_r <= k_r - LINK_W'(1);
      default: k_r <= k_r;
    endcase
  end

  // Result register, loaded by the final step of each item.
  always_ff @(posedge clk) begin
    if (ucw.fin) begin
      out_res_r   <= res_r;
      out_rv_r    <= (res_r != HEAD_IDX);
      out_cnt_r   <= count_r;
      out_first_r <= (count_r != '0) ? head_next_r : HEAD_IDX;
      out_last_r  <= (count_r != '0) ? head_prev_r : HEAD_IDX;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_last_r, out_first_r, out_cnt_r, out_res_r});
  assign out_tuser  = out_rv_r;

`ifndef SYNTHESIS
  a_count_limit : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= HEAD_IDX)
    else $error("list count above pool size");

  a_clear_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (!out_valid_r && !in_tready))
    else $error("channel active during clearing pass");

  a_empty_ends : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cnt_r == '0) |-> (out_first_r == HEAD_IDX && out_last_r == HEAD_IDX))
    else $error("empty list reported with a first or last node");
`endif

endmodule
